FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the profile position core.
// Depends on nothing; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

FILE: sv/tpp_pkg.sv
// Types, constants and the divider step function of the profile position core.
// Depends on nothing.
`timescale 1ns / 1ps

package tpp_pkg;

  typedef struct packed {
    logic [16:0] time_fraction;
    logic        linear_mode;
  } in_item_t;

  typedef struct packed {
    logic [16:0] distance_fraction;
    logic        out_of_range;
  } out_item_t;

  localparam logic [2:0] REG_START_SPEED     = 3'd0;
  localparam logic [2:0] REG_ACCEL_MAGNITUDE = 3'd1;
  localparam logic [2:0] REG_FIRST_RAMP_TIME = 3'd2;
  localparam logic [2:0] REG_LAST_RAMP_TIME  = 3'd3;
  localparam logic [2:0] REG_TOTAL_TIME      = 3'd4;
  localparam logic [2:0] REG_TOTAL_DISTANCE  = 3'd5;

  localparam logic [1:0] SGN_ZERO = 2'd0;
  localparam logic [1:0] SGN_POS  = 2'd1;
  localparam logic [1:0] SGN_NEG  = 2'd2;

  localparam logic [15:0] ACCEL_RESET = 16'd8389;
  localparam logic [16:0] FRAC_ONE    = 17'd65536;
  localparam int unsigned DIST_SCALE  = 1000;

  localparam int unsigned STAGES     = 12;
  localparam int unsigned CFG_SETTLE = 4;
  localparam int unsigned SETTLE_W   = $clog2(CFG_SETTLE + 1);

  typedef struct packed {
    logic [23:0] rem;
    logic [5:0]  q;
  } div_chunk_t;

  // Six restoring division steps; the remainder stays below the divisor.
  function automatic div_chunk_t div_chunk(input logic [23:0] rem_in,
                                           input logic [5:0]  bits_in,
                                           input logic [23:0] divisor);
    logic [24:0] trial;
    logic [23:0] rem;
    div_chunk_t  res;
    rem = rem_in;
    res.q = '0;
    for (int i = 5; i >= 0; i--) begin
      trial = {rem, bits_in[i]};
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
        res.q[i] = 1'b1;
      end
      rem = trial[23:0];
    end
    res.rem = rem;
    return res;
  endfunction

endpackage

FILE: sv/trapezoid_profile_position_core.sv
// Trapezoidal speed-profile position core: time fraction in, distance fraction out.
// Depends on tpp_pkg and assert_macros.svh.
//
//   channel  | handshake                     | beat
//   ---------+-------------------------------+---------------------------
//   item     | item_valid / item_ready       | in_item_t
//   result   | result_valid / result_ready   | out_item_t
//   config   | cfg_write (no back-pressure)  | cfg_index, cfg_data
//
// One beat enters per cycle while item_ready is high; the twelve-stage datapath has no
// feedback, so the rate is one beat per cycle unless result_ready is low or the profile
// constants are settling. Reset is synchronous; after reset and after each register write
// item_ready stays low while the derived profile constants settle.
// A stalled result holds its stage; upstream stages keep filling any empty stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module trapezoid_profile_position_core
  import tpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  in_item_t    item,
  output logic        result_valid,
  input  logic        result_ready,
  output out_item_t   result,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [23:0] start_speed;
  logic [15:0] accel_magnitude;
  logic [20:0] first_ramp_time;
  logic [20:0] last_ramp_time;
  logic [19:0] total_time;
  logic [23:0] total_distance;
  logic [SETTLE_W-1:0] settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_speed     <= '0;
      accel_magnitude <= ACCEL_RESET;
      first_ramp_time <= '0;
      last_ramp_time  <= '0;
      total_time      <= '0;
      total_distance  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_START_SPEED:     start_speed     <= cfg_data;
        REG_ACCEL_MAGNITUDE: accel_magnitude <= cfg_data[15:0];
        REG_FIRST_RAMP_TIME: first_ramp_time <= cfg_data[20:0];
        REG_LAST_RAMP_TIME:  last_ramp_time  <= cfg_data[20:0];
        REG_TOTAL_TIME:      total_time      <= cfg_data[19:0];
        REG_TOTAL_DISTANCE:  total_distance  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= SETTLE_W'(CFG_SETTLE);
    end else if (cfg_write) begin
      settle <= SETTLE_W'(CFG_SETTLE);
    end else if (settle != '0) begin
      settle <= settle - SETTLE_W'(1);
    end
  end

  // Profile constants derived from the registers.
  logic [20:0]        abs0, abs1;
  logic [24:0]        r0_w, r1_w;
  logic signed [26:0] b2_w;
  logic [40:0]        dv0_prod;

  assign abs0 = first_ramp_time[20] ? 21'(~first_ramp_time + 21'd1) : first_ramp_time;
  assign abs1 = last_ramp_time[20] ? 21'(~last_ramp_time + 21'd1) : last_ramp_time;
  assign r0_w = {abs0, 4'b0};
  assign r1_w = {abs1, 4'b0};
  assign b2_w = $signed({3'b0, total_time, 4'b0}) - $signed({2'b0, r1_w});
  assign dv0_prod = 41'(accel_magnitude) * 41'(r0_w);

  logic [24:0]        c1_r0;
  logic [1:0]         c1_s0, c1_s1;
  logic [27:0]        c1_v0;
  logic signed [26:0] c1_b2, c1_d2;
  logic [32:0]        c1_dv0;

  always_ff @(posedge clk) begin
    c1_r0  <= r0_w;
    c1_s0  <= (first_ramp_time == '0) ? SGN_ZERO : (first_ramp_time[20] ? SGN_NEG : SGN_POS);
    c1_s1  <= (last_ramp_time == '0) ? SGN_ZERO : (last_ramp_time[20] ? SGN_NEG : SGN_POS);
    c1_v0  <= {start_speed, 4'b0};
    c1_b2  <= b2_w;
    c1_d2  <= b2_w - $signed({2'b0, r0_w});
    c1_dv0 <= dv0_prod[40:8];
  end

  logic [57:0] acc0_prod;
  logic [52:0] lin0_prod;

  assign acc0_prod = 58'(c1_dv0) * 58'(c1_r0);
  assign lin0_prod = 53'(c1_v0) * 53'(c1_r0);

  logic [56:0]        c2_acc0;
  logic [52:0]        c2_lin0;
  logic signed [34:0] c2_vm;
  logic [24:0]        c2_r0;
  logic [1:0]         c2_s0, c2_s1;
  logic [27:0]        c2_v0;
  logic signed [26:0] c2_b2, c2_d2;

  always_ff @(posedge clk) begin
    c2_acc0 <= acc0_prod[57:1];
    c2_lin0 <= lin0_prod;
    unique case (c1_s0)
      SGN_POS: c2_vm <= $signed({7'b0, c1_v0}) + $signed({2'b0, c1_dv0});
      SGN_NEG: c2_vm <= $signed({7'b0, c1_v0}) - $signed({2'b0, c1_dv0});
      default: c2_vm <= $signed({7'b0, c1_v0});
    endcase
    c2_r0 <= c1_r0;
    c2_s0 <= c1_s0;
    c2_s1 <= c1_s1;
    c2_v0 <= c1_v0;
    c2_b2 <= c1_b2;
    c2_d2 <= c1_d2;
  end

  logic signed [63:0] c3_dist0, c3_vmd2;
  logic signed [34:0] c3_vm;
  logic [24:0]        c3_r0;
  logic [1:0]         c3_s0, c3_s1;
  logic [27:0]        c3_v0;
  logic signed [26:0] c3_b2;

  always_ff @(posedge clk) begin
    unique case (c2_s0)
      SGN_POS: c3_dist0 <= $signed({11'b0, c2_lin0}) + $signed({7'b0, c2_acc0});
      SGN_NEG: c3_dist0 <= $signed({11'b0, c2_lin0}) - $signed({7'b0, c2_acc0});
      default: c3_dist0 <= $signed({11'b0, c2_lin0});
    endcase
    c3_vmd2 <= 64'(c2_vm) * 64'(c2_d2);
    c3_vm   <= c2_vm;
    c3_r0   <= c2_r0;
    c3_s0   <= c2_s0;
    c3_s1   <= c2_s1;
    c3_v0   <= c2_v0;
    c3_b2   <= c2_b2;
  end

  logic signed [63:0] c4_dist0, c4_base2;
  logic signed [34:0] c4_vm;
  logic [24:0]        c4_r0;
  logic [1:0]         c4_s0, c4_s1;
  logic [27:0]        c4_v0;
  logic signed [26:0] c4_b2;

  always_ff @(posedge clk) begin
    c4_dist0 <= c3_dist0;
    c4_base2 <= c3_dist0 + c3_vmd2;
    c4_vm    <= c3_vm;
    c4_r0    <= c3_r0;
    c4_s0    <= c3_s0;
    c4_s1    <= c3_s1;
    c4_v0    <= c3_v0;
    c4_b2    <= c3_b2;
  end

  // Pipeline flow control.
  logic [STAGES-1:0] stage_valid;
  logic [STAGES-1:0] advance;

  always_comb begin
    advance[STAGES-1] = !stage_valid[STAGES-1] || result_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      advance[k] = !stage_valid[k] || advance[k+1];
    end
  end

  assign item_ready   = advance[0] && (settle == '0);
  assign result_valid = stage_valid[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (advance[0]) begin
        stage_valid[0] <= item_valid && item_ready;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (advance[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  logic [16:0] tf_line   [STAGES-1];
  logic        pass_line [STAGES-1];

  always_ff @(posedge clk) begin
    if (advance[0]) begin
      tf_line[0]   <= item.time_fraction;
      pass_line[0] <= item.linear_mode || (total_distance == '0);
    end
    for (int k = 1; k < STAGES - 1; k++) begin
      if (advance[k]) begin
        tf_line[k]   <= tf_line[k-1];
        pass_line[k] <= pass_line[k-1];
      end
    end
  end

  // Stage 1: elapsed time.
  logic [36:0] at_prod;
  logic [24:0] s1_at;

  assign at_prod = 37'(tf_line[0]) * 37'(total_time);

  always_ff @(posedge clk) begin
    if (advance[1]) begin
      s1_at <= at_prod[36:12];
    end
  end

  // Stage 2: phase selection.
  logic signed [26:0] at_s, r0_s, diff0, diff2;
  logic [25:0]        t_next;
  logic signed [34:0] v_next;
  logic [1:0]         sgn_next;
  logic signed [63:0] base_next;

  assign at_s  = $signed({2'b0, s1_at});
  assign r0_s  = $signed({2'b0, c4_r0});
  assign diff0 = at_s - r0_s;
  assign diff2 = at_s - c4_b2;

  always_comb begin
    if (at_s < r0_s) begin
      t_next    = {1'b0, s1_at};
      v_next    = $signed({7'b0, c4_v0});
      sgn_next  = c4_s0;
      base_next = '0;
    end else if (at_s < c4_b2) begin
      t_next    = diff0[25:0];
      v_next    = c4_vm;
      sgn_next  = SGN_ZERO;
      base_next = c4_dist0;
    end else begin
      t_next    = diff2[25:0];
      v_next    = c4_vm;
      sgn_next  = c4_s1;
      base_next = c4_base2;
    end
  end

  logic [25:0]        s2_t;
  logic signed [34:0] s2_v;
  logic [1:0]         s2_sgn;
  logic signed [63:0] s2_base;

  always_ff @(posedge clk) begin
    if (advance[2]) begin
      s2_t    <= t_next;
      s2_v    <= v_next;
      s2_sgn  <= sgn_next;
      s2_base <= base_next;
    end
  end

  // Stage 3: linear term and speed change.
  logic signed [63:0] lin_prod;
  logic [41:0]        dv_prod;
  logic signed [63:0] s3_lin, s3_base;
  logic [33:0]        s3_dv;
  logic [25:0]        s3_t;
  logic [1:0]         s3_sgn;

  assign lin_prod = 64'(s2_v) * 64'($signed({1'b0, s2_t}));
  assign dv_prod  = 42'(accel_magnitude) * 42'(s2_t);

  always_ff @(posedge clk) begin
    if (advance[3]) begin
      s3_lin  <= lin_prod;
      s3_dv   <= dv_prod[41:8];
      s3_t    <= s2_t;
      s3_sgn  <= s2_sgn;
      s3_base <= s2_base;
    end
  end

  // Stage 4: acceleration term.
  logic [59:0]        acc_prod;
  logic signed [63:0] s4_sum;
  logic [58:0]        s4_acc;
  logic [1:0]         s4_sgn;

  assign acc_prod = 60'(s3_dv) * 60'(s3_t);

  always_ff @(posedge clk) begin
    if (advance[4]) begin
      s4_sum <= s3_base + s3_lin;
      s4_acc <= acc_prod[59:1];
      s4_sgn <= s3_sgn;
    end
  end

  // Stage 5: position.
  logic signed [63:0] pos;
  logic               s5_neg;
  logic [46:0]        s5_pq;

  always_comb begin
    case (s4_sgn)
      SGN_POS: pos = s4_sum + $signed({5'b0, s4_acc});
      SGN_NEG: pos = s4_sum - $signed({5'b0, s4_acc});
      default: pos = s4_sum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance[5]) begin
      s5_neg <= pos[63];
      s5_pq  <= pos[62:16];
    end
  end

  // Stage 6: scale to the distance unit.
  logic [56:0] s6_num;
  logic        s6_neg;

  always_ff @(posedge clk) begin
    if (advance[6]) begin
      s6_num <= 57'(s5_pq) * 57'(DIST_SCALE);
      s6_neg <= s5_neg;
    end
  end

  // Stage 7: range check against 65537 times the distance; divider setup.
  logic [40:0] limit;
  logic [23:0] s7_rem;
  logic [17:0] s7_low;
  logic        s7_neg, s7_over;

  assign limit = {1'b0, total_distance, 16'b0} + {17'b0, total_distance};

  always_ff @(posedge clk) begin
    if (advance[7]) begin
      s7_over <= s6_num >= 57'(limit);
      s7_rem  <= s6_num[41:18];
      s7_low  <= s6_num[17:0];
      s7_neg  <= s6_neg;
    end
  end

  // Stages 8 to 10: quotient, six bits per stage.
  div_chunk_t  chunk8, chunk9, chunk10;
  logic [23:0] s8_rem, s9_rem;
  logic [5:0]  s8_q;
  logic [11:0] s8_low, s9_q;
  logic [5:0]  s9_low;
  logic [17:0] s10_q;
  logic        s8_neg, s8_over, s9_neg, s9_over, s10_neg, s10_over;

  assign chunk8  = div_chunk(s7_rem, s7_low[17:12], total_distance);
  assign chunk9  = div_chunk(s8_rem, s8_low[11:6], total_distance);
  assign chunk10 = div_chunk(s9_rem, s9_low, total_distance);

  always_ff @(posedge clk) begin
    if (advance[8]) begin
      s8_rem  <= chunk8.rem;
      s8_q    <= chunk8.q;
      s8_low  <= s7_low[11:0];
      s8_neg  <= s7_neg;
      s8_over <= s7_over;
    end
    if (advance[9]) begin
      s9_rem  <= chunk9.rem;
      s9_q    <= {s8_q, chunk9.q};
      s9_low  <= s8_low[5:0];
      s9_neg  <= s8_neg;
      s9_over <= s8_over;
    end
    if (advance[10]) begin
      s10_q    <= {s9_q, chunk10.q};
      s10_neg  <= s9_neg;
      s10_over <= s9_over;
    end
  end

  // Stage 11: saturation and result register.
  out_item_t result_next;

  always_comb begin
    if (pass_line[STAGES-2]) begin
      if (tf_line[STAGES-2] > FRAC_ONE) begin
        result_next = '{distance_fraction: FRAC_ONE, out_of_range: 1'b1};
      end else begin
        result_next = '{distance_fraction: tf_line[STAGES-2], out_of_range: 1'b0};
      end
    end else if (s10_neg) begin
      result_next = '{distance_fraction: '0, out_of_range: 1'b1};
    end else if (s10_over) begin
      result_next = '{distance_fraction: FRAC_ONE, out_of_range: 1'b1};
    end else begin
      result_next = '{distance_fraction: s10_q[16:0], out_of_range: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (advance[STAGES-1]) begin
      result <= result_next;
    end
  end

  logic quot_live;

  assign quot_live = stage_valid[10] && !pass_line[10] && !s10_neg && !s10_over;

  `ASSERT_CLK(a_cfg_blocks_items, clk, rst, cfg_write |=> !item_ready, "item taken after write")
  `ASSERT_CLK(a_entry_moves, clk, rst, stage_valid[0] && advance[1] |=> stage_valid[1], "beat lost")
  `ASSERT_CLK(a_quot_fits, clk, rst, quot_live |-> s10_q <= 18'(FRAC_ONE), "quotient too wide")
  `ASSERT_CLK(a_result_sat, clk, rst, result_valid |-> result.distance_fraction <= FRAC_ONE, "fraction above one")

endmodule
